FILE: hw/rtl/udd_pkg.sv
package udd_pkg;

    // Field widths.
    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;
    localparam int LOW_W  = 10;

    // Default depth of the first-occurrence table.
    localparam int TABLE_DEPTH_DEF = 256;

    // Byte order mark as read in little-endian order (bytes FF FE).
    localparam logic [UNIT_W-1:0] BOM_UNIT = 16'hFEFF;

    // High surrogate range and surrogate payload mask.
    localparam logic [UNIT_W-1:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [LOW_W-1:0]  SURR_MASK       = 10'h3FF;

    // Offset of the supplementary planes.
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Line break units that are dropped.
    localparam logic [UNIT_W-1:0] UNIT_CR = 16'h000D;
    localparam logic [UNIT_W-1:0] UNIT_LF = 16'h000A;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

endpackage

FILE: hw/rtl/udd_ram.sv
module udd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/utf16_decode_dedup.sv
// UTF-16 decoder that passes each code point on only at its first appearance
// in a file.
// Input channel: one code unit per request, s_tdata holds the two stored bytes
// and s_tuser marks the byte order mark that opens a file. The mark picks the
// byte order (FF FE is little-endian, anything else big-endian), empties the
// seen table and drops any held high surrogate; it yields no result.
// Output channel: one request per new code point, with m_tuser set when the
// seen table was full and the point was not stored.
// s_tready is high only while the sequencer is idle. A unit that yields no
// result (mark, high surrogate, CR, LF) starts no search. A new code point
// passes the search and emit states before m_tvalid; the search reads the
// stored entries (at most TABLE_DEPTH) of the table RAM one entry per cycle
// through its single registered read port. A point already stored frees the
// input as soon as its match is read back.
// The finished result sits in an output register, so the next unit is taken
// while it waits; a second result waits in the emit state until the receiver
// takes the first. After reset the byte order is little-endian, the table is
// empty and no surrogate is held; no clearing pass is needed.
module utf16_decode_dedup #(
    parameter int TABLE_DEPTH = udd_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] first_byte, [15:8] second_byte
    input  logic [0:0]  s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [0:0]  m_tuser    // [0] table_full
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int CP_W  = udd_pkg::CP_W;
    localparam int LOW_W = udd_pkg::LOW_W;

    udd_pkg::state_t state_reg, state_next;

    logic             big_endian_reg, big_endian_next;
    logic             high_pending_reg, high_pending_next;
    logic [LOW_W-1:0] high_bits_reg, high_bits_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic             out_valid_reg, out_valid_next;
    logic [CP_W-1:0]  out_cp_reg, out_cp_next;
    logic             out_full_reg, out_full_next;

    logic [7:0]              b0;
    logic [7:0]              b1;
    logic                    sof;
    logic [udd_pkg::UNIT_W-1:0] unit;
    logic [CP_W-1:0]         cand_cp;
    logic                    is_high;
    logic                    is_break;
    logic                    accept;
    logic                    needs_search;
    logic                    match;
    logic                    search_done;
    logic                    emit_fire;
    logic                    store;
    logic                    issue;
    logic [CP_W-1:0]         rd_data;

    // Unit assembly and classification of the incoming request.
    always_comb begin
        b0      = s_tdata[7:0];
        b1      = s_tdata[15:8];
        sof     = s_tuser[0];
        unit    = big_endian_reg ? {b0, b1} : {b1, b0};
        cand_cp = high_pending_reg
                ? ({1'b0, high_bits_reg, unit[LOW_W-1:0] & udd_pkg::SURR_MASK}
                   + udd_pkg::SUPP_BASE)
                : {{(CP_W - udd_pkg::UNIT_W){1'b0}}, unit};
        is_high  = !high_pending_reg && (unit >= udd_pkg::SURR_HIGH_FIRST)
                 && (unit <= udd_pkg::SURR_HIGH_LAST);
        is_break = !high_pending_reg
                 && ((unit == udd_pkg::UNIT_CR) || (unit == udd_pkg::UNIT_LF));
        accept       = s_tvalid && s_tready;
        needs_search = accept && !sof && !is_high && !is_break;
    end

    // Search and emit status.
    assign match       = (state_reg == udd_pkg::ST_SEARCH) && pend_reg && (rd_data == cp_reg);
    assign search_done = (state_reg == udd_pkg::ST_SEARCH) && !pend_reg
                       && (idx_reg == count_reg);
    assign emit_fire   = (state_reg == udd_pkg::ST_EMIT) && (!out_valid_reg || m_tready);
    assign store       = emit_fire && (count_reg < DEPTH_C);
    assign issue       = (state_reg == udd_pkg::ST_SEARCH) && (idx_reg < count_reg) && !match;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            udd_pkg::ST_IDLE: begin
                if (needs_search) begin
                    state_next = udd_pkg::ST_SEARCH;
                end
            end
            udd_pkg::ST_SEARCH: begin
                if (match) begin
                    state_next = udd_pkg::ST_IDLE;
                end else if (search_done) begin
                    state_next = udd_pkg::ST_EMIT;
                end
            end
            udd_pkg::ST_EMIT: begin
                if (emit_fire) begin
                    state_next = udd_pkg::ST_IDLE;
                end
            end
            default: state_next = udd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        s_tready          = (state_reg == udd_pkg::ST_IDLE);
        big_endian_next   = big_endian_reg;
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pend_next         = issue;
        cp_next           = cp_reg;
        out_cp_next       = out_cp_reg;
        out_full_next     = out_full_reg;
        out_valid_next    = out_valid_reg && !m_tready;

        // A byte order mark restarts the file; other units update the decoder.
        if (accept) begin
            if (sof) begin
                big_endian_next   = ({b1, b0} != udd_pkg::BOM_UNIT);
                high_pending_next = 1'b0;
                high_bits_next    = '0;
                count_next        = '0;
            end else if (high_pending_reg) begin
                high_pending_next = 1'b0;
                high_bits_next    = '0;
            end else if (is_high) begin
                high_pending_next = 1'b1;
                high_bits_next    = unit[LOW_W-1:0] & udd_pkg::SURR_MASK;
            end
            if (needs_search) begin
                cp_next  = cand_cp;
                idx_next = '0;
            end
        end

        // Walk the table one entry per cycle.
        if (issue) begin
            idx_next = idx_reg + 1'b1;
        end

        // Hand the new point to the output register and store it if room.
        if (emit_fire) begin
            out_valid_next = 1'b1;
            out_cp_next    = cp_reg;
            out_full_next  = !store;
            if (store) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= udd_pkg::ST_IDLE;
            big_endian_reg   <= 1'b0;
            high_pending_reg <= 1'b0;
            high_bits_reg    <= '0;
            count_reg        <= '0;
            idx_reg          <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            big_endian_reg   <= big_endian_next;
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cp_reg       <= cp_next;
        out_cp_reg   <= out_cp_next;
        out_full_reg <= out_full_next;
    end

    // Seen table.
    udd_ram #(
        .WIDTH (CP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cp_reg),
        .rd_en   (issue),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - CP_W){1'b0}}, out_cp_reg};
    assign m_tuser  = out_full_reg;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("seen count beyond table depth");

    // The read pointer stays within the filled part during a search.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == udd_pkg::ST_SEARCH) |-> (idx_reg <= count_reg))
        else $error("search pointer beyond fill count");

    // A read in flight exists only while searching.
    a_pend_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == udd_pkg::ST_SEARCH))
        else $error("table read pending outside search");

    // Storing a point grows the fill count by one.
    a_store_count: assert property (@(posedge aclk) disable iff (!aresetn)
        store |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fill count did not advance on store");

endmodule
